/* sv/uart_baud_and_line_config_assert.svh */
// ----------------------------------------------------------------------------
// UART baud and line configuration assertion macros
// Shared property templates for the checker of the configuration block.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_AND_LINE_CONFIG_ASSERT_SVH
`define UART_BAUD_AND_LINE_CONFIG_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UBL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UBL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ubl_pkg.sv */
// ----------------------------------------------------------------------------
// UART baud and line configuration package
// Types and constants shared by the block and its checker, and the divider step.
// ----------------------------------------------------------------------------
`default_nettype none

package ubl_pkg;

   localparam int REF_W      = 30;
   localparam int BAUD_W     = 24;
   localparam int WORD_W     = 4;
   localparam int STOP_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int INT_W      = 16;
   localparam int FRAC_W     = 6;
   localparam int LC_W       = 8;
   localparam int NUM_W      = 34;
   localparam int DEN_W      = 20;
   localparam int QUOT_W     = INT_W + FRAC_W;
   localparam int HEAD_W     = NUM_W - QUOT_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = QUOT_W / BITS_PER_STAGE;
   localparam int PIPE_LAST  = DIV_STAGES + 2;

   localparam logic [REF_W-1:0]  REF_RESET = 30'd48000000;
   localparam logic [WORD_W-1:0] WORD_MIN  = 4'd5;
   localparam logic [WORD_W-1:0] WORD_MAX  = 4'd8;
   localparam logic [STOP_W-1:0] STOP_ONE  = 2'd1;
   localparam logic [STOP_W-1:0] STOP_TWO  = 2'd2;
   localparam logic [BAUD_W-1:0] BAUD_MIN  = 24'd110;
   localparam logic [BAUD_W-1:0] BAUD_MAX  = 24'd460800;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_WORD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_STOP = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BAUD = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LC_W-1:0]     lc;
      logic [DEN_W-1:0]    den;
      logic [DEN_W-1:0]    rem;
      logic [QUOT_W-1:0]   low;
      logic [QUOT_W-1:0]   quot;
      logic                ovf;
   } ubl_stage_type;

   // Restoring division: BITS_PER_STAGE quotient bits per call.
   function automatic ubl_stage_type ubl_div_step(ubl_stage_type s);
      ubl_stage_type    r;
      logic [DEN_W:0]   part;
      logic             qbit;
      r = s;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
         part  = {r.rem, r.low[QUOT_W-1]};
         r.low = {r.low[QUOT_W-2:0], 1'b0};
         qbit  = (part >= {1'b0, r.den});
         if (qbit) begin
            part = part - {1'b0, r.den};
         end
         r.rem  = part[DEN_W-1:0];
         r.quot = {r.quot[QUOT_W-2:0], qbit};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/uart_baud_and_line_config.sv */
// ----------------------------------------------------------------------------
// UART baud and line configuration
// Validates a serial setting and computes the 16x fractional divisor and
// the line control byte.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while results are taken; a stalled result
// holds req_ready low once the stages upstream of it have filled. The restoring
// divider yields two quotient bits per stage over eleven stages.
// Stalled stages hold their beat while empty stages upstream keep filling.
// Reset empties the pipeline and loads 48 MHz into the reference clock.
`default_nettype none

module uart_baud_and_line_config (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [ubl_pkg::REF_W-1:0]       csr_wr_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ubl_pkg::BAUD_W-1:0]      req_baud_rate,
   input  wire logic [ubl_pkg::WORD_W-1:0]      req_word_bits,
   input  wire logic [ubl_pkg::STOP_W-1:0]      req_stop_count,
   input  wire logic                            req_parity_on,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [ubl_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ubl_pkg::INT_W-1:0]            rsp_int_divisor,
   output logic [ubl_pkg::FRAC_W-1:0]           rsp_frac_divisor,
   output logic [ubl_pkg::LC_W-1:0]             rsp_line_control
);
   import ubl_pkg::*;

   logic [REF_W-1:0]    ref_ff;
   logic [PIPE_LAST:0]  vld_ff;
   logic [PIPE_LAST:0]  adv;
   ubl_stage_type       st_ff [0:PIPE_LAST-1];
   ubl_stage_type       st_in [0:PIPE_LAST-1];
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [INT_W-1:0]    idiv_ff, idiv_in;
   logic [FRAC_W-1:0]   fdiv_ff, fdiv_in;
   logic [LC_W-1:0]     lc_ff, lc_in;

   logic                word_ok, stop_ok, baud_ok;
   logic [NUM_W-1:0]    num;
   logic [1:0]          len_code;
   ubl_stage_type       last;

   always_comb begin
      adv[PIPE_LAST] = !vld_ff[PIPE_LAST] || rsp_ready;
      for (int i = PIPE_LAST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[0];

   always_comb begin
      word_ok  = (req_word_bits >= WORD_MIN) && (req_word_bits <= WORD_MAX);
      stop_ok  = (req_stop_count == STOP_ONE) || (req_stop_count == STOP_TWO);
      baud_ok  = (req_baud_rate >= BAUD_MIN) && (req_baud_rate <= BAUD_MAX);
      num      = {1'b0, ref_ff, 3'b000} + NUM_W'(req_baud_rate);
      len_code = 2'(req_word_bits - WORD_MIN);

      st_in[0].status = !word_ok ? STATUS_BAD_WORD :
                        !stop_ok ? STATUS_BAD_STOP :
                        !baud_ok ? STATUS_BAD_BAUD : STATUS_OK;
      st_in[0].lc     = {req_parity_on, len_code, 1'b1,
                         (req_stop_count == STOP_TWO), req_parity_on,
                         req_parity_on, 1'b0};
      st_in[0].den    = {req_baud_rate[DEN_W-2:0], 1'b0};
      st_in[0].rem    = DEN_W'(num[NUM_W-1:QUOT_W]);
      st_in[0].low    = num[QUOT_W-1:0];
      st_in[0].quot   = '0;
      st_in[0].ovf    = 1'b0;

      st_in[1]     = st_ff[0];
      st_in[1].ovf = (st_ff[0].rem >= st_ff[0].den);

      for (int i = 2; i < PIPE_LAST; i++) begin
         st_in[i] = ubl_div_step(st_ff[i-1]);
      end

      last = st_ff[PIPE_LAST-1];
      status_in = last.status;
      if (last.status != STATUS_OK) begin
         idiv_in = '0;
         fdiv_in = '0;
         lc_in   = '0;
      end else if (last.ovf) begin
         idiv_in = '1;
         fdiv_in = '1;
         lc_in   = last.lc;
      end else begin
         idiv_in = last.quot[QUOT_W-1:FRAC_W];
         fdiv_in = last.quot[FRAC_W-1:0];
         lc_in   = last.lc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
         vld_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            ref_ff <= csr_wr_data;
         end
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i <= PIPE_LAST; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PIPE_LAST; i++) begin
         if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
      if (adv[PIPE_LAST]) begin
         status_ff <= status_in;
         idiv_ff   <= idiv_in;
         fdiv_ff   <= fdiv_in;
         lc_ff     <= lc_in;
      end
   end

   assign rsp_valid        = vld_ff[PIPE_LAST];
   assign rsp_status       = status_ff;
   assign rsp_int_divisor  = idiv_ff;
   assign rsp_frac_divisor = fdiv_ff;
   assign rsp_line_control = lc_ff;

endmodule

`default_nettype wire

/* sv/ubl_checker.sv */
// ----------------------------------------------------------------------------
// UART baud and line configuration checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_baud_and_line_config_assert.svh"

module ubl_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            csr_wr_en,
   input wire logic [ubl_pkg::REF_W-1:0]       csr_wr_data,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic [ubl_pkg::BAUD_W-1:0]      req_baud_rate,
   input wire logic [ubl_pkg::WORD_W-1:0]      req_word_bits,
   input wire logic [ubl_pkg::STOP_W-1:0]      req_stop_count,
   input wire logic                            req_parity_on,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [ubl_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic [ubl_pkg::INT_W-1:0]       rsp_int_divisor,
   input wire logic [ubl_pkg::FRAC_W-1:0]      rsp_frac_divisor,
   input wire logic [ubl_pkg::LC_W-1:0]        rsp_line_control
);
   import ubl_pkg::*;

   // A rejected setting carries no divisor and no line control.
   `UBL_ASSERT_NOW(a_invalid_zero, rsp_valid && (rsp_status != STATUS_OK),
      (rsp_int_divisor == '0) && (rsp_frac_divisor == '0) && (rsp_line_control == '0),
      "rejected setting with nonzero result fields")

   // An accepted setting always enables the FIFO and leaves bit 0 clear.
   `UBL_ASSERT_NOW(a_ok_fifo, rsp_valid && (rsp_status == STATUS_OK),
      rsp_line_control[4] && !rsp_line_control[0],
      "accepted setting with bad FIFO or reserved bit")

   // Parity enable, even and stick bits always move together.
   `UBL_ASSERT_NOW(a_parity_bits, rsp_valid,
      (rsp_line_control[1] == rsp_line_control[2]) &&
      (rsp_line_control[2] == rsp_line_control[7]),
      "parity control bits disagree")

   // A stalled result beat holds until taken.
   `UBL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_int_divisor) &&
      $stable(rsp_frac_divisor) && $stable(rsp_line_control),
      "stalled result beat changed")

endmodule

bind uart_baud_and_line_config ubl_checker u_ubl_checker (.*);

`default_nettype wire
